FILE: rtl/core/msq_pkg.sv
// Package: record type, status codes and the service-order compare for the priority queue.
package msq_pkg;

    // One queued record.
    typedef struct packed {
        logic [15:0] truck_id;
        logic [1:0]  class_level;
        logic [15:0] tonnage;
        logic [15:0] total_items;
        logic [7:0]  distinct_items;
        logic [1:0]  perishable;
        logic [1:0]  frozen;
    } t_rec;

    // Result status codes.
    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_FULL      = 2'd1,
        ST_EMPTY     = 2'd2,
        ST_BAD_CLASS = 2'd3
    } t_status;

    // Item kinds.
    localparam logic KIND_INSERT = 1'b0;
    localparam logic KIND_POP    = 1'b1;

    // Class level that marks an invalid record.
    localparam logic [1:0] CLASS_NONE = 2'd0;

    // Control broadcast to every cell of the chain.
    typedef struct packed {
        logic do_insert;
        logic do_pop;
        t_rec rec;
    } t_cell_ctl;

    // True when record a must leave strictly before record b.
    function automatic logic goes_before(input t_rec a, input t_rec b);
        logic res;
        if (a.class_level != b.class_level) begin
            res = (a.class_level < b.class_level);
        end else if (a.tonnage != b.tonnage) begin
            res = (a.tonnage > b.tonnage);
        end else if (a.total_items != b.total_items) begin
            res = (a.total_items > b.total_items);
        end else if (a.perishable != b.perishable) begin
            res = (a.perishable > b.perishable);
        end else begin
            res = (a.frozen > b.frozen);
        end
        return res;
    endfunction

endpackage

FILE: rtl/core/msq_if.sv
// Interfaces: valid/ready channels for queue items and queue results.
interface msq_in_if;
    logic        valid;
    logic        ready;
    logic        kind;
    logic [15:0] truck_id;
    logic [1:0]  class_level;
    logic [15:0] tonnage;
    logic [15:0] total_items;
    logic [7:0]  distinct_items;
    logic [1:0]  perishable;
    logic [1:0]  frozen;

    modport source (
        output valid, kind, truck_id, class_level, tonnage, total_items,
               distinct_items, perishable, frozen,
        input  ready
    );
    modport sink (
        input  valid, kind, truck_id, class_level, tonnage, total_items,
               distinct_items, perishable, frozen,
        output ready
    );
endinterface

interface msq_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  status;
    logic [15:0] out_truck_id;
    logic [1:0]  out_class_level;
    logic [15:0] out_tonnage;
    logic [15:0] out_total_items;
    logic [7:0]  out_distinct_items;
    logic [1:0]  out_perishable;
    logic [1:0]  out_frozen;
    logic [4:0]  occupancy;

    modport source (
        output valid, status, out_truck_id, out_class_level, out_tonnage,
               out_total_items, out_distinct_items, out_perishable, out_frozen,
               occupancy,
        input  ready
    );
    modport sink (
        input  valid, status, out_truck_id, out_class_level, out_tonnage,
               out_total_items, out_distinct_items, out_perishable, out_frozen,
               occupancy,
        output ready
    );
endinterface

FILE: rtl/core/msq_cell.sv
// Queue cell: holds one record and shifts toward its neighbors on insert and pop.
module msq_cell (
    input  logic                  i_clk,
    input  msq_pkg::t_cell_ctl    i_ctl,
    input  logic                  i_valid,
    input  logic                  i_left_flag,
    input  msq_pkg::t_rec         i_left_rec,
    input  msq_pkg::t_rec         i_right_rec,
    output logic                  o_flag,
    output msq_pkg::t_rec         o_rec
);

    msq_pkg::t_rec r_rec;
    msq_pkg::t_rec n_rec;

    // The new record belongs at or before this cell when the cell is empty
    // or the new record leaves strictly before the one held here.
    assign o_flag = !i_valid || msq_pkg::goes_before(i_ctl.rec, r_rec);
    assign o_rec  = r_rec;

    // Insert: the first flagged cell takes the new record, later ones shift right.
    // Pop: every cell takes its right neighbor.
    always_comb begin
        n_rec = r_rec;
        if (i_ctl.do_insert) begin
            if (o_flag && !i_left_flag) begin
                n_rec = i_ctl.rec;
            end else if (o_flag) begin
                n_rec = i_left_rec;
            end
        end else if (i_ctl.do_pop) begin
            n_rec = i_right_rec;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rec <= n_rec;
    end

endmodule

FILE: rtl/core/multikey_sorted_priority_queue.sv
// Top level: sorted priority queue built as a chain of compare-and-shift cells.
//
//   Channel  Dir  Modport  Beat carries
//   i_in     in   sink     kind, truck_id, class_level, tonnage, total_items,
//                          distinct_items, perishable, frozen
//   o_out    out  source   status, popped record fields, occupancy
//
// All DEPTH cells compare against the new record in parallel and shift in the same
// edge, so one beat is accepted per cycle while the output register can take it.
// The result is held in an output register; a new beat is accepted while that
// register is empty or being drained in the same cycle.
// Reset (synchronous, active low) empties the queue and the output register.
// Record storage is not cleared; only cells below the entry count are ever read.
module multikey_sorted_priority_queue #(
    parameter int DEPTH = 16
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    msq_in_if.sink    i_in,
    msq_out_if.source o_out
);

    localparam int CW = $clog2(DEPTH + 1);
    localparam int OW = (CW > 5) ? CW : 5;

    logic [CW-1:0] r_count;
    logic [CW-1:0] n_count;

    logic          r_out_valid;
    msq_pkg::t_status r_status;
    msq_pkg::t_rec r_out_rec;
    logic [4:0]    r_occ;

    msq_pkg::t_status n_status;
    msq_pkg::t_rec n_out_rec;
    logic [4:0]    n_occ;
    logic [OW-1:0] w_count_ext;

    logic          w_accept;
    logic          w_full;
    logic          w_empty;
    msq_pkg::t_rec w_new_rec;
    msq_pkg::t_cell_ctl w_ctl;

    logic          w_flag [DEPTH];
    msq_pkg::t_rec w_rec  [DEPTH];

    // Input beat handshake.
    assign i_in.ready = !r_out_valid || o_out.ready;
    assign w_accept   = i_in.valid && i_in.ready;
    assign w_full     = (r_count >= CW'(DEPTH));
    assign w_empty    = (r_count == '0);

    assign w_new_rec.truck_id       = i_in.truck_id;
    assign w_new_rec.class_level    = i_in.class_level;
    assign w_new_rec.tonnage        = i_in.tonnage;
    assign w_new_rec.total_items    = i_in.total_items;
    assign w_new_rec.distinct_items = i_in.distinct_items;
    assign w_new_rec.perishable     = i_in.perishable;
    assign w_new_rec.frozen         = i_in.frozen;

    // Decode the accepted beat into cell control, status and next count.
    always_comb begin
        w_ctl.do_insert = 1'b0;
        w_ctl.do_pop    = 1'b0;
        w_ctl.rec       = w_new_rec;
        n_status        = msq_pkg::ST_OK;
        n_out_rec       = '0;
        n_count         = r_count;
        if (i_in.kind == msq_pkg::KIND_INSERT) begin
            if (i_in.class_level == msq_pkg::CLASS_NONE) begin
                n_status = msq_pkg::ST_BAD_CLASS;
            end else if (w_full) begin
                n_status = msq_pkg::ST_FULL;
            end else begin
                w_ctl.do_insert = w_accept;
                n_count         = r_count + CW'(1);
            end
        end else begin
            if (w_empty) begin
                n_status = msq_pkg::ST_EMPTY;
            end else begin
                w_ctl.do_pop = w_accept;
                n_out_rec    = w_rec[0];
                n_count      = r_count - CW'(1);
            end
        end
    end

    assign w_count_ext = OW'(n_count);
    assign n_occ       = w_count_ext[4:0];

    // Chain of cells; cell zero holds the record that leaves first.
    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        logic          w_left_flag;
        msq_pkg::t_rec w_left_rec;
        msq_pkg::t_rec w_right_rec;

        if (g == 0) begin : g_head
            assign w_left_flag = 1'b0;
            assign w_left_rec  = w_new_rec;
        end else begin : g_body
            assign w_left_flag = w_flag[g-1];
            assign w_left_rec  = w_rec[g-1];
        end

        if (g == DEPTH - 1) begin : g_tail
            assign w_right_rec = w_rec[g];
        end else begin : g_inner
            assign w_right_rec = w_rec[g+1];
        end

        msq_cell u_cell (
            .i_clk       (i_clk),
            .i_ctl       (w_ctl),
            .i_valid     (CW'(g) < r_count),
            .i_left_flag (w_left_flag),
            .i_left_rec  (w_left_rec),
            .i_right_rec (w_right_rec),
            .o_flag      (w_flag[g]),
            .o_rec       (w_rec[g])
        );
    end

    // Entry count and result valid.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_accept) begin
                r_count     <= n_count;
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Result payload register.
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_status  <= n_status;
            r_out_rec <= n_out_rec;
            r_occ     <= n_occ;
        end
    end

    assign o_out.valid              = r_out_valid;
    assign o_out.status             = r_status;
    assign o_out.out_truck_id       = r_out_rec.truck_id;
    assign o_out.out_class_level    = r_out_rec.class_level;
    assign o_out.out_tonnage        = r_out_rec.tonnage;
    assign o_out.out_total_items    = r_out_rec.total_items;
    assign o_out.out_distinct_items = r_out_rec.distinct_items;
    assign o_out.out_perishable     = r_out_rec.perishable;
    assign o_out.out_frozen         = r_out_rec.frozen;
    assign o_out.occupancy          = r_occ;

    // The count never passes the number of cells.
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(DEPTH))
        else $error("entry count above depth");

    // A successful pop always returns a record of a valid class.
    a_pop_class: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_ctl.do_pop) |=> (r_out_rec.class_level != msq_pkg::CLASS_NONE))
        else $error("popped record with invalid class");

    // A pop on an empty queue leaves the count at zero and reports empty.
    a_empty_pop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && i_in.kind == msq_pkg::KIND_POP && w_empty)
        |=> (r_count == '0 && r_status == msq_pkg::ST_EMPTY))
        else $error("empty pop changed the queue");

    // Insert and pop never act in the same cycle.
    a_one_op: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(w_ctl.do_insert && w_ctl.do_pop))
        else $error("insert and pop both active");

endmodule

FILE: verif/multikey_sorted_priority_queue_test.sv
// Testbench for the sorted truck priority queue: directed, random and full-queue stall traffic.
`timescale 1ns / 1ps

module multikey_sorted_priority_queue_test;

    localparam int QUEUE_DEPTH = 16;
    localparam int HOLD_CYCLES = 80;
    localparam int STALL_LIMIT = 2000;
    localparam int DRAIN_CYCLES = 20;
    localparam int REPORT_LIMIT = 10;

    // One expected unload beat.
    typedef struct {
        msq_pkg::t_status status;
        msq_pkg::t_rec    rec;
        logic [4:0]       occupancy;
    } t_unload_result;

    logic i_clk;
    logic i_rst_n;

    msq_in_if  load_ch ();
    msq_out_if unload_ch ();

    // Predictor state: records in service order, and the results still owed.
    msq_pkg::t_rec  dock_q[$];
    t_unload_result expected_unloads[$];

    int fail_count = 0;
    int send_idle_pct;
    int recv_idle_pct;
    int hold_trigger;
    int hold_seen = 0;
    int hold_left = 0;
    int stall_cycles = 0;

    multikey_sorted_priority_queue #(
        .DEPTH(QUEUE_DEPTH)
    ) u_dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_in   (load_ch),
        .o_out  (unload_ch)
    );

    // Free-running clock.
    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // True when record a is served strictly ahead of record b.
    function automatic bit ranks_ahead(input msq_pkg::t_rec a, input msq_pkg::t_rec b);
        if (a.class_level != b.class_level) begin
            return a.class_level < b.class_level;
        end
        return {a.tonnage, a.total_items, a.perishable, a.frozen} >
               {b.tonnage, b.total_items, b.perishable, b.frozen};
    endfunction

    // Apply one accepted beat to the predicted queue and record the result it owes.
    function automatic void predict_unload(input logic kind, input msq_pkg::t_rec rec);
        t_unload_result res;
        int pos;
        res.status = msq_pkg::ST_OK;
        res.rec = '0;
        if (kind == msq_pkg::KIND_INSERT) begin
            if (rec.class_level == msq_pkg::CLASS_NONE) begin
                res.status = msq_pkg::ST_BAD_CLASS;
            end else if (dock_q.size() >= QUEUE_DEPTH) begin
                res.status = msq_pkg::ST_FULL;
            end else begin
                pos = dock_q.size();
                for (int i = 0; i < dock_q.size(); i++) begin
                    if (ranks_ahead(rec, dock_q[i])) begin
                        pos = i;
                        break;
                    end
                end
                dock_q.insert(pos, rec);
            end
        end else begin
            if (dock_q.size() == 0) begin
                res.status = msq_pkg::ST_EMPTY;
            end else begin
                res.rec = dock_q.pop_front();
            end
        end
        res.occupancy = 5'(dock_q.size());
        expected_unloads.push_back(res);
    endfunction

    function automatic void note_failure(input string msg);
        fail_count++;
        if (fail_count <= REPORT_LIMIT) begin
            $display("ERROR at %0t: %s", $realtime, msg);
        end
    endfunction

    function automatic msq_pkg::t_rec make_rec(input logic [15:0] id, input logic [1:0] cls,
                                               input logic [15:0] ton,
                                               input logic [15:0] total,
                                               input logic [7:0] distinct,
                                               input logic [1:0] per,
                                               input logic [1:0] frz);
        msq_pkg::t_rec r;
        r.truck_id       = id;
        r.class_level    = cls;
        r.tonnage        = ton;
        r.total_items    = total;
        r.distinct_items = distinct;
        r.perishable     = per;
        r.frozen         = frz;
        return r;
    endfunction

    // Pick a key value: a near tie or an extreme, each a quarter of the time, otherwise anything.
    function automatic logic [15:0] random_key();
        case ($urandom_range(3))
            0: return 16'($urandom_range(3));
            1: return $urandom_range(1) ? 16'hFFFF : 16'h0000;
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic msq_pkg::t_rec random_truck();
        msq_pkg::t_rec r;
        r.truck_id       = 16'($urandom);
        r.class_level    = ($urandom_range(99) < 5) ? msq_pkg::CLASS_NONE
                                                    : 2'($urandom_range(1, 3));
        r.tonnage        = random_key();
        r.total_items    = random_key();
        r.distinct_items = 8'($urandom_range(255));
        r.perishable     = ($urandom_range(99) < 85) ? 2'($urandom_range(1, 2))
                                                     : 2'($urandom_range(3));
        r.frozen         = ($urandom_range(99) < 85) ? 2'($urandom_range(1, 2))
                                                     : 2'($urandom_range(3));
        return r;
    endfunction

    // Offer one beat, with random idle cycles ahead of it, and predict it once taken.
    task automatic send_item(input logic kind, input msq_pkg::t_rec rec);
        while ($urandom_range(99) < send_idle_pct) begin
            load_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        load_ch.valid          <= 1'b1;
        load_ch.kind           <= kind;
        load_ch.truck_id       <= rec.truck_id;
        load_ch.class_level    <= rec.class_level;
        load_ch.tonnage        <= rec.tonnage;
        load_ch.total_items    <= rec.total_items;
        load_ch.distinct_items <= rec.distinct_items;
        load_ch.perishable     <= rec.perishable;
        load_ch.frozen         <= rec.frozen;
        @(posedge i_clk);
        while (load_ch.ready !== 1'b1) begin
            @(posedge i_clk);
        end
        predict_unload(kind, rec);
    endtask

    // Field extremes, the empty, bad-class and OK statuses, key tie-breaks and arrival order on equal keys.
    task automatic test_ordering_edges();
        send_item(msq_pkg::KIND_POP, random_truck());
        send_item(msq_pkg::KIND_INSERT, make_rec(16'hFFFF, msq_pkg::CLASS_NONE, 16'hFFFF,
                                                 16'hFFFF, 8'hFF, 2'd3, 2'd3));
        send_item(msq_pkg::KIND_INSERT, make_rec(16'h0001, 2'd3, 16'h0000, 16'h0000, 8'h00,
                                                 2'd1, 2'd1));
        send_item(msq_pkg::KIND_INSERT, make_rec(16'hFFFF, 2'd1, 16'hFFFF, 16'hFFFF, 8'hFF,
                                                 2'd2, 2'd2));
        send_item(msq_pkg::KIND_INSERT, make_rec(16'h0002, 2'd1, 16'hFFFF, 16'hFFFF, 8'h00,
                                                 2'd2, 2'd2));
        send_item(msq_pkg::KIND_INSERT, make_rec(16'h0004, 2'd1, 16'hFFFF, 16'hFFFE, 8'h5A,
                                                 2'd3, 2'd3));
        send_item(msq_pkg::KIND_INSERT, make_rec(16'h0005, 2'd2, 16'd100, 16'd5, 8'hA5,
                                                 2'd1, 2'd2));
        send_item(msq_pkg::KIND_INSERT, make_rec(16'h0006, 2'd2, 16'd100, 16'd5, 8'h01,
                                                 2'd2, 2'd1));
        send_item(msq_pkg::KIND_INSERT, make_rec(16'h0007, 2'd2, 16'd100, 16'd5, 8'h80,
                                                 2'd2, 2'd3));
        // Out-of-range perishable and frozen codes sort by their raw value.
        send_item(msq_pkg::KIND_INSERT, make_rec(16'h0008, 2'd2, 16'd100, 16'd5, 8'h7F,
                                                 2'd0, 2'd0));
        send_item(msq_pkg::KIND_INSERT, make_rec(16'h0003, 2'd3, 16'h0000, 16'h0000, 8'hFE,
                                                 2'd1, 2'd1));
        send_item(msq_pkg::KIND_INSERT, make_rec(16'h1234, msq_pkg::CLASS_NONE, 16'd1, 16'd1,
                                                 8'd1, 2'd1, 2'd1));
        // Drain everything, ending with one pop on an empty queue.
        repeat (10) send_item(msq_pkg::KIND_POP, random_truck());
    endtask

    // Bursts that lean toward inserts, toward pops, or neither, so occupancy swings.
    task automatic test_random_traffic(input int n_items);
        int sent;
        int burst_len;
        int insert_pct;
        sent = 0;
        while (sent < n_items) begin
            burst_len = $urandom_range(5, 40);
            case ($urandom_range(2))
                0: insert_pct = 85;
                1: insert_pct = 20;
                default: insert_pct = 50;
            endcase
            for (int i = 0; i < burst_len && sent < n_items; i++) begin
                send_item(($urandom_range(99) < insert_pct) ? msq_pkg::KIND_INSERT
                                                            : msq_pkg::KIND_POP,
                          random_truck());
                sent++;
            end
        end
    endtask

    // Receiver holds off while inserts pile up: the queue fills, drops, and stalls its input.
    task automatic test_full_queue_stall();
        msq_pkg::t_rec r;
        hold_trigger <= hold_trigger + 1;
        repeat (QUEUE_DEPTH + 2) begin
            r = random_truck();
            r.class_level = 2'($urandom_range(1, 3));
            send_item(msq_pkg::KIND_INSERT, r);
        end
        // A bad class is reported ahead of a full queue.
        r = random_truck();
        r.class_level = msq_pkg::CLASS_NONE;
        send_item(msq_pkg::KIND_INSERT, r);
        repeat (QUEUE_DEPTH + 2) send_item(msq_pkg::KIND_POP, random_truck());
    endtask

    // Receiver: held off in reset, random stalls, or a long hold-off when one is requested.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            unload_ch.ready <= 1'b0;
        end else if (hold_trigger != hold_seen) begin
            hold_seen       <= hold_trigger;
            hold_left       <= HOLD_CYCLES;
            unload_ch.ready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left       <= hold_left - 1;
            unload_ch.ready <= 1'b0;
        end else begin
            unload_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Compare each result beat with the oldest expectation.
    always @(posedge i_clk) begin : check_unloads
        t_unload_result want;
        if (i_rst_n && unload_ch.valid === 1'b1 && unload_ch.ready === 1'b1) begin
            if (expected_unloads.size() == 0) begin
                note_failure($sformatf("result beat with none expected, status %0d",
                                       unload_ch.status));
            end else begin
                want = expected_unloads.pop_front();
                if (unload_ch.status !== want.status ||
                    unload_ch.out_truck_id !== want.rec.truck_id ||
                    unload_ch.out_class_level !== want.rec.class_level ||
                    unload_ch.out_tonnage !== want.rec.tonnage ||
                    unload_ch.out_total_items !== want.rec.total_items ||
                    unload_ch.out_distinct_items !== want.rec.distinct_items ||
                    unload_ch.out_perishable !== want.rec.perishable ||
                    unload_ch.out_frozen !== want.rec.frozen ||
                    unload_ch.occupancy !== want.occupancy) begin
                    note_failure($sformatf({"mismatch (expected/actual): status %0d/%0d ",
                        "id %h/%h class %0d/%0d ton %h/%h total %h/%h distinct %h/%h ",
                        "perishable %0d/%0d frozen %0d/%0d occupancy %0d/%0d"},
                        want.status, unload_ch.status,
                        want.rec.truck_id, unload_ch.out_truck_id,
                        want.rec.class_level, unload_ch.out_class_level,
                        want.rec.tonnage, unload_ch.out_tonnage,
                        want.rec.total_items, unload_ch.out_total_items,
                        want.rec.distinct_items, unload_ch.out_distinct_items,
                        want.rec.perishable, unload_ch.out_perishable,
                        want.rec.frozen, unload_ch.out_frozen,
                        want.occupancy, unload_ch.occupancy));
                end
            end
        end
    end

    // Watchdog: too many cycles without any beat on either channel ends the run.
    always @(posedge i_clk) begin
        if ((load_ch.valid === 1'b1 && load_ch.ready === 1'b1) ||
            (unload_ch.valid === 1'b1 && unload_ch.ready === 1'b1)) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= STALL_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    // Test sequence.
    initial begin
        send_idle_pct = 29;
        recv_idle_pct = 76;
        hold_trigger  = 0;

        i_rst_n                <= 1'b0;
        load_ch.valid          <= 1'b0;
        load_ch.kind           <= msq_pkg::KIND_INSERT;
        load_ch.truck_id       <= '0;
        load_ch.class_level    <= msq_pkg::CLASS_NONE;
        load_ch.tonnage        <= '0;
        load_ch.total_items    <= '0;
        load_ch.distinct_items <= '0;
        load_ch.perishable     <= '0;
        load_ch.frozen         <= '0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_ordering_edges();
        test_random_traffic(450);
        test_full_queue_stall();

        send_idle_pct = 76;
        recv_idle_pct = 29;
        test_random_traffic(450);

        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random_traffic(430);

        // Let every owed result arrive, then watch for stray beats.
        load_ch.valid <= 1'b0;
        while (expected_unloads.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (fail_count == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

FILE: sim.f
rtl/core/msq_pkg.sv
rtl/core/msq_if.sv
rtl/core/msq_cell.sv
rtl/core/multikey_sorted_priority_queue.sv
verif/multikey_sorted_priority_queue_test.sv
